/* rtl/core/ffqp_pkg.sv */
package ffqp_pkg;

  localparam int unsigned CNT_W   = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [31:0] MAX_READ_LEN = 32'd2097151;
  localparam logic [31:0] CNT_MAX      = 32'h001F_FFFF;
  localparam logic [CNT_W-1:0] CAP_LEN =
    (MAX_READ_LEN > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : MAX_READ_LEN[CNT_W-1:0];

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LC = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BASE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WARN = 2'd2;

  // ASCII codes
  localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_AT = 8'h40;
  localparam logic [BYTE_W-1:0] CH_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC = 8'h43;
  localparam logic [BYTE_W-1:0] CH_UG = 8'h47;
  localparam logic [BYTE_W-1:0] CH_UN = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_UT = 8'h54;
  localparam logic [BYTE_W-1:0] CH_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC = 8'h63;
  localparam logic [BYTE_W-1:0] CH_LG = 8'h67;
  localparam logic [BYTE_W-1:0] CH_LN = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LT = 8'h74;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    ROLE_IDLE    = 3'd0,
    ROLE_FA_HDR  = 3'd1,
    ROLE_FA_SEQ  = 3'd2,
    ROLE_FQ_HDR  = 3'd3,
    ROLE_FQ_SEQ  = 3'd4,
    ROLE_FQ_PLUS = 3'd5,
    ROLE_FQ_QUAL = 3'd6,
    ROLE_BAD     = 3'd7
  } role_t;

  typedef struct packed {
    role_t            role;
    logic             at_line_start;
    logic [CNT_W-1:0] base_count;
    logic [CNT_W-1:0] invalid_count;
    logic             overflow_seen;
    logic             read_is_fastq;
  } parse_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] base_char;
    logic [CNT_W-1:0]  read_length;
    logic [CNT_W-1:0]  invalid_bases;
    logic              is_fastq;
    logic              too_long;
    logic              empty_read;
    logic              drop_read;
    logic              last;
  } result_t;

endpackage

/* rtl/core/ffqp_in_if.sv */
interface ffqp_in_if;
  import ffqp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

/* rtl/core/ffqp_out_if.sv */
interface ffqp_out_if;
  import ffqp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] base_char;
  logic [CNT_W-1:0]  read_length;
  logic [CNT_W-1:0]  invalid_bases;
  logic              is_fastq;
  logic              too_long;
  logic              empty_read;
  logic              drop_read;
  logic              last;

  modport source (
    output valid, output result_kind, output base_char, output read_length,
    output invalid_bases, output is_fastq, output too_long, output empty_read,
    output drop_read, output last, input ready
  );
  modport sink (
    input valid, input result_kind, input base_char, input read_length,
    input invalid_bases, input is_fastq, input too_long, input empty_read,
    input drop_read, input last, output ready
  );
endinterface

/* rtl/core/fasta_fastq_read_parser.sv */
// Channel  Dir  Payload                                    Accepted when
// in_ch    in   byte_in, end_of_input                      valid & ready
// out_ch   out  result_kind, base_char, read_length, ...   valid & ready
// cfg_*    in   cfg_index selects register, cfg_wdata      cfg_we
//
// One byte a cycle unless the output stalls or the hold register is full: input
// register, then one short parse step into the result register. A byte giving
// two results (a base or record, then the end-of-input record) parks the second
// in the hold register, which blocks the next byte until it drains. Reset (rst_n
// low, synchronous) returns to the idle role at a line start and clears all valid
// flags. A stalled output holds its result; an empty input register still fills.
module fasta_fastq_read_parser
  import ffqp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ffqp_in_if.sink              in_ch,
  ffqp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eoi_r;
  parse_state_t      state_r;
  parse_state_t      state_nxt;
  logic [CNT_W-1:0]  min_len_r;
  logic              keep_lc_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              hold_valid_r;
  result_t           hold_r;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_cnt;
  logic              out_free;
  logic              proceed;

  ffqp_step u_step (
    .st           (state_r),
    .byte_in      (in_byte_r),
    .end_of_input (in_eoi_r),
    .min_len      (min_len_r),
    .keep_lc      (keep_lc_r),
    .st_nxt       (state_nxt),
    .res0         (res0),
    .res1         (res1),
    .res_cnt      (res_cnt)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign proceed     = in_valid_r && !hold_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r              <= 1'b0;
      out_valid_r             <= 1'b0;
      hold_valid_r            <= 1'b0;
      min_len_r               <= '0;
      keep_lc_r               <= 1'b0;
      state_r.role            <= ROLE_IDLE;
      state_r.at_line_start   <= 1'b1;
      state_r.base_count      <= '0;
      state_r.invalid_count   <= '0;
      state_r.overflow_seen   <= 1'b0;
      state_r.read_is_fastq   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_LEN: min_len_r <= cfg_wdata;
          CFG_KEEP_LC: keep_lc_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) in_valid_r <= 1'b1;
      else if (proceed)               in_valid_r <= 1'b0;

      if (proceed) begin
        state_r      <= state_nxt;
        out_valid_r  <= (res_cnt != 2'd0);
        hold_valid_r <= (res_cnt == 2'd2);
      end else if (hold_valid_r && out_free) begin
        // advance the second result of the last byte
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.byte_in;
      in_eoi_r  <= in_ch.end_of_input;
    end
    if (proceed) begin
      out_r  <= res0;
      hold_r <= res1;
    end else if (hold_valid_r && out_free) begin
      out_r  <= hold_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_r.kind;
  assign out_ch.base_char     = out_r.base_char;
  assign out_ch.read_length   = out_r.read_length;
  assign out_ch.invalid_bases = out_r.invalid_bases;
  assign out_ch.is_fastq      = out_r.is_fastq;
  assign out_ch.too_long      = out_r.too_long;
  assign out_ch.empty_read    = out_r.empty_read;
  assign out_ch.drop_read     = out_r.drop_read;
  assign out_ch.last          = out_r.last;

  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("hold register full with output register empty");

  a_hold_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> hold_r.last)
    else $error("second result of a byte not marked last");

  a_idle_at_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.role == ROLE_IDLE) |-> state_r.at_line_start)
    else $error("idle role away from a line start");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proceed) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_eoi_r)))
    else $error("stalled input request lost or changed");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.invalid_count <= state_r.base_count)
    else $error("invalid count above base count");

endmodule

/* rtl/core/ffqp_step.sv */
module ffqp_step
  import ffqp_pkg::*;
(
  input  parse_state_t      st,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              end_of_input,
  input  logic [CNT_W-1:0]  min_len,
  input  logic              keep_lc,
  output parse_state_t      st_nxt,
  output result_t           res0,
  output result_t           res1,
  output logic [1:0]        res_cnt
);

  function automatic result_t close_rec(input logic [CNT_W-1:0] bc,
                                        input logic [CNT_W-1:0] ic,
                                        input logic ov, input logic fq,
                                        input logic [CNT_W-1:0] mn);
    result_t r;
    r               = '0;
    r.kind          = KIND_END;
    r.read_length   = bc;
    r.invalid_bases = ic;
    r.is_fastq      = fq;
    r.too_long      = ov;
    r.empty_read    = (bc == '0);
    r.drop_read     = (bc == '0) || (bc < mn);
    return r;
  endfunction

  logic             nl;
  logic             take;
  logic             first_v;
  logic             eoi_close;
  logic             bad_base;
  logic [BYTE_W-1:0] mapped;
  role_t            role_n;
  logic [CNT_W-1:0] bc;
  logic [CNT_W-1:0] ic;
  logic             ov;
  logic             fq;
  result_t          first_r;
  result_t          end_r;

  assign nl = (byte_in == CH_NL);

  // base mapping: ACGTN pass, n to N, acgt folded unless kept, else N and flagged
  always_comb begin
    bad_base = 1'b0;
    mapped   = byte_in;
    case (byte_in)
      CH_UA, CH_UC, CH_UG, CH_UT, CH_UN: mapped = byte_in;
      CH_LN:                             mapped = CH_UN;
      CH_LA, CH_LC, CH_LG, CH_LT:        mapped = keep_lc ? byte_in : byte_in - CASE_OFFSET;
      default: begin
        mapped   = CH_UN;
        bad_base = 1'b1;
      end
    endcase
  end

  always_comb begin
    role_n  = st.role;
    bc      = st.base_count;
    ic      = st.invalid_count;
    ov      = st.overflow_seen;
    fq      = st.read_is_fastq;
    take    = 1'b0;
    first_v = 1'b0;
    first_r = '0;

    case (st.role)
      ROLE_IDLE: begin
        if (byte_in == CH_GT) begin
          bc = '0; ic = '0; ov = 1'b0; fq = 1'b0;
          role_n = ROLE_FA_HDR;
        end else if (byte_in == CH_AT) begin
          bc = '0; ic = '0; ov = 1'b0; fq = 1'b1;
          role_n = ROLE_FQ_HDR;
        end else begin
          first_v      = 1'b1;
          first_r.kind = KIND_WARN;
          role_n       = nl ? ROLE_IDLE : ROLE_BAD;
        end
      end
      ROLE_FA_HDR: begin
        if (nl) role_n = ROLE_FA_SEQ;
      end
      ROLE_FA_SEQ: begin
        if (st.at_line_start && (byte_in == CH_GT)) begin
          // next header closes this read and opens a fresh one
          first_v = 1'b1;
          first_r = close_rec(st.base_count, st.invalid_count, st.overflow_seen,
                              st.read_is_fastq, min_len);
          bc = '0; ic = '0; ov = 1'b0; fq = 1'b0;
          role_n = ROLE_FA_HDR;
        end else if (!nl) begin
          take = 1'b1;
        end
      end
      ROLE_FQ_HDR: begin
        if (nl) role_n = ROLE_FQ_SEQ;
      end
      ROLE_FQ_SEQ: begin
        if (nl) role_n = ROLE_FQ_PLUS;
        else    take = 1'b1;
      end
      ROLE_FQ_PLUS: begin
        if (nl) role_n = ROLE_FQ_QUAL;
      end
      ROLE_FQ_QUAL: begin
        if (nl) begin
          first_v = 1'b1;
          first_r = close_rec(st.base_count, st.invalid_count, st.overflow_seen,
                              st.read_is_fastq, min_len);
          role_n  = ROLE_IDLE;
        end
      end
      default: begin
        if (nl) role_n = ROLE_IDLE;
      end
    endcase

    if (take && (byte_in != CH_CR)) begin
      if (bc == CAP_LEN) begin
        ov = 1'b1;
      end else begin
        first_v           = 1'b1;
        first_r.kind      = KIND_BASE;
        first_r.base_char = mapped;
        if (bad_base) ic = ic + 1'b1;
        bc = bc + 1'b1;
      end
    end

    eoi_close = end_of_input && (role_n != ROLE_IDLE) && (role_n != ROLE_BAD);
    end_r     = close_rec(bc, ic, ov, fq, min_len);

    res0 = first_v ? first_r : end_r;
    res1 = end_r;
    res0.last = !(first_v && eoi_close);
    res1.last = 1'b1;
    res_cnt   = {1'b0, first_v} + {1'b0, eoi_close};

    st_nxt.role          = end_of_input ? ROLE_IDLE : role_n;
    st_nxt.at_line_start = nl || end_of_input;
    st_nxt.base_count    = bc;
    st_nxt.invalid_count = ic;
    st_nxt.overflow_seen = ov;
    st_nxt.read_is_fastq = fq;
  end

endmodule
